[rtl/lphj_pkg.sv]
package lphj_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 4096;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int MAX_MATCHES = 63;
    localparam int MIN_LOG2    = 4;

    localparam logic [31:0] SENTINEL_KEY = 32'h8000_0000;
    localparam logic [31:0] FMIX_C1      = 32'h85eb_ca6b;
    localparam logic [31:0] FMIX_C2      = 32'hc2b2_ae35;
    localparam logic [31:0] CRC_POLY     = 32'h82F6_3B78;

    // request codes
    localparam logic [1:0] REQ_CLEAR  = 2'd0;
    localparam logic [1:0] REQ_INSERT = 2'd1;
    localparam logic [1:0] REQ_PROBE  = 2'd2;
    localparam logic [1:0] REQ_NONE   = 2'd3;

    // result status codes
    localparam logic [1:0] STS_OK       = 2'd0;
    localparam logic [1:0] STS_SENTINEL = 2'd1;
    localparam logic [1:0] STS_REJECT   = 2'd2;
    localparam logic [1:0] STS_OVERFLOW = 2'd3;

    // register byte addresses
    localparam logic [2:0] ADDR_BUILD_ROWS = 3'd0;
    localparam logic [2:0] ADDR_HASH_MODE  = 3'd4;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [31:0] key;
    } t_in;

    typedef struct packed {
        logic        hit;
        logic [11:0] build_row;
        logic [31:0] probe_row;
        logic [5:0]  match_total;
        logic [1:0]  status;
        logic        last;
    } t_out;

    typedef struct packed {
        logic        valid;
        logic [11:0] row;
        logic [31:0] key;
    } t_slot;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DISPATCH,
        ST_HASH,
        ST_READ,
        ST_CHECK,
        ST_RESP
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic       take;
        logic       clr_start;
        logic       sweep;
        logic       ins_take;
        logic       prb_take;
        logic       hash_init;
        logic       hash_step;
        logic       walk_init;
        logic       advance;
        logic       write_slot;
        logic       hit_count;
        logic       set_status;
        logic [1:0] status_val;
        logic       emit_hit;
        logic       emit_end;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] req;
        logic       sweep_last;
        logic       limit;
        logic       sentinel;
        logic       hash_done;
        logic       slot_valid;
        logic       key_eq;
        logic       n_full;
        logic       last_step;
        logic       out_free;
    } t_sts;

    // address mask of the smallest power-of-two capacity >= 16 with cap*10 >= rows*17
    function automatic logic [ADDR_W-1:0] cap_mask(input logic [11:0] rows);
        logic [31:0] prod;
        logic [31:0] m;
        prod = {20'd0, rows} * 32'd17;
        m    = 32'(TABLE_DEPTH - 1);
        for (int i = ADDR_W - 1; i >= MIN_LOG2; i--) begin
            if ((32'd10 << i) >= prod) begin
                m = (32'd1 << i) - 32'd1;
            end
        end
        return m[ADDR_W-1:0];
    endfunction

endpackage

[rtl/lphj_datapath.sv]
module lphj_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lphj_pkg::t_in         i_in_data,
    input  logic [11:0]           i_build_rows,
    input  logic                  i_hash_mode,
    input  lphj_pkg::t_cmd        i_cmd,
    output lphj_pkg::t_sts        o_sts,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output lphj_pkg::t_out        o_out_data
);
    import lphj_pkg::*;

    // slot memory
    t_slot r_mem [TABLE_DEPTH];
    t_slot r_rdata;

    logic [1:0]        r_req;
    logic [31:0]       r_key;
    logic [ADDR_W-1:0] r_mask;
    logic [ADDR_W-1:0] r_sweep;
    logic [11:0]       r_ins_cnt;
    logic [31:0]       r_prb_cnt;
    logic [11:0]       r_row;
    logic [31:0]       r_prow;
    logic [5:0]        r_n;
    logic [1:0]        r_status;
    logic [31:0]       r_h;
    logic [2:0]        r_hcnt;
    logic              r_mode;
    logic [ADDR_W-1:0] r_idx;
    logic [ADDR_W-1:0] r_steps;
    logic              r_ovalid;
    t_out              r_out;

    logic [31:0] n_h;
    logic [31:0] mix;
    logic [31:0] mul_c;
    logic [63:0] prod;
    logic        out_free;
    logic        mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    t_slot       mem_wdata;

    // eight CRC32C bit steps, reflected
    function automatic logic [31:0] crc8(input logic [31:0] c);
        logic [31:0] v;
        v = c;
        for (int b = 0; b < 8; b++) begin
            v = (v >> 1) ^ (v[0] ? CRC_POLY : 32'd0);
        end
        return v;
    endfunction

    // hash step: fmix32 over its xorshift-multiply rounds, CRC32C a byte per cycle
    always_comb begin
        mix   = r_h ^ (r_h >> ((r_hcnt == 3'd1) ? 13 : 16));
        mul_c = (r_hcnt == 3'd0) ? FMIX_C1 : FMIX_C2;
        prod  = {32'd0, mix} * {32'd0, mul_c};
        if (r_mode) begin
            n_h = crc8(r_h);
        end else if (r_hcnt == 3'd2) begin
            n_h = mix;
        end else begin
            n_h = prod[31:0];
        end
    end

    assign out_free = !r_ovalid || !i_out_stall;

    // memory write port: sweep clears, insert fills
    always_comb begin
        mem_we    = i_cmd.sweep || i_cmd.write_slot;
        mem_waddr = i_cmd.sweep ? r_sweep : r_idx;
        mem_wdata = i_cmd.sweep ? '0 : t_slot'{valid: 1'b1, row: r_row, key: r_key};
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[r_idx];
    end

    // item and walk registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req     <= REQ_NONE;
            r_mask    <= cap_mask(12'd0);
            r_sweep   <= '0;
            r_ins_cnt <= '0;
            r_prb_cnt <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            if (i_cmd.take) begin
                r_req    <= i_in_data.req_type;
                r_key    <= i_in_data.key;
                r_row    <= '0;
                r_prow   <= '0;
                r_n      <= '0;
                r_status <= STS_OK;
            end
            if (i_cmd.clr_start) begin
                r_mask    <= cap_mask(i_build_rows);
                r_sweep   <= '0;
                r_ins_cnt <= '0;
                r_prb_cnt <= '0;
            end
            if (i_cmd.sweep) begin
                r_sweep <= r_sweep + 1'b1;
            end
            if (i_cmd.ins_take) begin
                r_row     <= r_ins_cnt;
                r_ins_cnt <= r_ins_cnt + 1'b1;
            end
            if (i_cmd.prb_take) begin
                r_prow    <= r_prb_cnt;
                r_prb_cnt <= r_prb_cnt + 1'b1;
            end
            if (i_cmd.hash_init) begin
                r_h    <= i_hash_mode ? ~r_key : r_key;
                r_mode <= i_hash_mode;
                r_hcnt <= '0;
            end
            if (i_cmd.hash_step) begin
                r_h    <= n_h;
                r_hcnt <= r_hcnt + 1'b1;
            end
            if (i_cmd.walk_init) begin
                r_idx   <= r_h[ADDR_W-1:0] & r_mask;
                r_steps <= '0;
            end
            if (i_cmd.advance) begin
                r_idx   <= (r_idx + 1'b1) & r_mask;
                r_steps <= r_steps + 1'b1;
            end
            if (i_cmd.hit_count) begin
                r_n <= r_n + 1'b1;
            end
            if (i_cmd.set_status) begin
                r_status <= i_cmd.status_val;
            end
            // output register
            if (i_cmd.emit_hit) begin
                r_ovalid <= 1'b1;
                r_out    <= t_out'{hit: 1'b1, build_row: r_rdata.row, probe_row: r_prow,
                                   match_total: '0, status: STS_OK, last: 1'b0};
            end else if (i_cmd.emit_end) begin
                r_ovalid <= 1'b1;
                r_out    <= t_out'{hit: 1'b0, build_row: r_row, probe_row: r_prow,
                                   match_total: r_n, status: r_status, last: 1'b1};
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // status to controller
    always_comb begin
        o_sts.req        = r_req;
        o_sts.sweep_last = (r_sweep == ADDR_W'(TABLE_DEPTH - 1));
        o_sts.limit      = (r_ins_cnt >= i_build_rows) ||
                           ({1'b0, r_ins_cnt} >= ({1'b0, r_mask} + 13'd1));
        o_sts.sentinel   = (r_key == SENTINEL_KEY);
        o_sts.hash_done  = r_mode ? (r_hcnt == 3'd4) : (r_hcnt == 3'd3);
        o_sts.slot_valid = r_rdata.valid;
        o_sts.key_eq     = (r_rdata.key == r_key);
        o_sts.n_full     = (r_n == 6'(MAX_MATCHES));
        o_sts.last_step  = (r_steps == r_mask);
        o_sts.out_free   = out_free;
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit_hit || i_cmd.emit_end) |-> out_free)
        else $error("result loaded over a held beat");
    a_write_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.write_slot |-> !r_rdata.valid)
        else $error("insert overwrote an occupied slot");
    a_match_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.hit_count |-> (r_n < 6'(MAX_MATCHES)))
        else $error("match count beyond limit");

endmodule

[rtl/lphj_ctrl.sv]
module lphj_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  lphj_pkg::t_sts i_sts,
    output lphj_pkg::t_cmd o_cmd
);
    import lphj_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_SWEEP;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_DISPATCH;
            end
            ST_SWEEP: begin
                if (i_sts.sweep_last) begin
                    n_state = (i_sts.req == REQ_CLEAR) ? ST_RESP : ST_IDLE;
                end
            end
            ST_DISPATCH: begin
                case (i_sts.req)
                    REQ_CLEAR:  n_state = ST_SWEEP;
                    REQ_INSERT: n_state = (i_sts.limit || i_sts.sentinel) ? ST_RESP : ST_HASH;
                    REQ_PROBE:  n_state = i_sts.sentinel ? ST_RESP : ST_HASH;
                    default:    n_state = ST_IDLE;
                endcase
            end
            ST_HASH: begin
                if (i_sts.hash_done) n_state = ST_READ;
            end
            ST_READ: n_state = ST_CHECK;
            ST_CHECK: begin
                if (!i_sts.slot_valid) begin
                    n_state = ST_RESP;
                end else if (i_sts.req == REQ_INSERT) begin
                    n_state = ST_READ;
                end else if (!(i_sts.key_eq && !i_sts.n_full && !i_sts.out_free)) begin
                    n_state = i_sts.last_step ? ST_RESP : ST_READ;
                end
            end
            ST_RESP: begin
                if (i_sts.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd      = '0;
        o_in_stall = (r_state != ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                o_cmd.take = i_in_valid;
            end
            ST_SWEEP: begin
                o_cmd.sweep = 1'b1;
            end
            ST_DISPATCH: begin
                case (i_sts.req)
                    REQ_CLEAR: begin
                        o_cmd.clr_start = 1'b1;
                    end
                    REQ_INSERT: begin
                        if (i_sts.limit) begin
                            o_cmd.set_status = 1'b1;
                            o_cmd.status_val = STS_REJECT;
                        end else begin
                            o_cmd.ins_take  = 1'b1;
                            o_cmd.hash_init = !i_sts.sentinel;
                            o_cmd.set_status = i_sts.sentinel;
                            o_cmd.status_val = STS_SENTINEL;
                        end
                    end
                    REQ_PROBE: begin
                        o_cmd.prb_take   = 1'b1;
                        o_cmd.hash_init  = !i_sts.sentinel;
                        o_cmd.set_status = i_sts.sentinel;
                        o_cmd.status_val = STS_SENTINEL;
                    end
                    default: ;
                endcase
            end
            ST_HASH: begin
                o_cmd.walk_init = i_sts.hash_done;
                o_cmd.hash_step = !i_sts.hash_done;
            end
            ST_READ: ;
            ST_CHECK: begin
                if (i_sts.slot_valid) begin
                    if (i_sts.req == REQ_INSERT) begin
                        o_cmd.advance = 1'b1;
                    end else if (i_sts.key_eq && !i_sts.n_full) begin
                        o_cmd.emit_hit  = i_sts.out_free;
                        o_cmd.hit_count = i_sts.out_free;
                        o_cmd.advance   = i_sts.out_free;
                    end else begin
                        o_cmd.advance    = 1'b1;
                        o_cmd.set_status = i_sts.key_eq;
                        o_cmd.status_val = STS_OVERFLOW;
                    end
                end else if (i_sts.req == REQ_INSERT) begin
                    o_cmd.write_slot = 1'b1;
                end
            end
            ST_RESP: begin
                o_cmd.emit_end = i_sts.out_free;
            end
            default: ;
        endcase
    end

    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.take |=> (r_state == ST_DISPATCH))
        else $error("accepted beat not dispatched");
    a_one_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.emit_hit && o_cmd.emit_end))
        else $error("two results in one cycle");
    a_resp_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit_end |=> (r_state == ST_IDLE))
        else $error("end result without return to idle");

endmodule

[rtl/linear_probe_hash_join_core.sv]
// Channel | Handshake              | Beat
// in      | i_in_valid/o_in_stall  | t_in  {req_type, key}
// out     | o_out_valid/i_out_stall| t_out {hit, build_row, probe_row, match_total, status, last}
// config  | APB psel/penable/pwrite| build_rows @0x0, hash_mode @0x4
//
// One item at a time. Insert or probe: a dispatch, the fmix32 or CRC32C hash steps,
// then per slot visited a registered memory read and a compare, then the end result.
// A clear sweeps all 4096 slots, one per cycle, then returns its result.
// After reset the same full sweep runs before the first item is taken.
// Output stall holds the result register and pauses a probe walk at the next hit.
module linear_probe_hash_join_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  lphj_pkg::t_in     i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output lphj_pkg::t_out    o_out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import lphj_pkg::*;

    logic [11:0] r_build_rows;
    logic        r_hash_mode;
    logic        cfg_wr;
    t_cmd        cmd;
    t_sts        sts;

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_build_rows <= '0;
            r_hash_mode  <= 1'b0;
        end else if (cfg_wr) begin
            if (paddr == ADDR_BUILD_ROWS) r_build_rows <= pwdata[11:0];
            if (paddr == ADDR_HASH_MODE)  r_hash_mode  <= pwdata[0];
        end
    end

    always_comb begin
        case (paddr)
            ADDR_BUILD_ROWS: prdata = {20'd0, r_build_rows};
            ADDR_HASH_MODE:  prdata = {31'd0, r_hash_mode};
            default:         prdata = '0;
        endcase
    end

    lphj_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    lphj_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_data    (i_in_data),
        .i_build_rows (r_build_rows),
        .i_hash_mode  (r_hash_mode),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_out_data   (o_out_data)
    );

endmodule
